FILE: sv/malc_pkg.sv
// Shared types and constants of the moving-average level classifier.
package malc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int BAND_W   = 3;

    // Reset values of the four band thresholds
    localparam logic [SAMPLE_W-1:0] THR_ONE_RST   = 10'd200;
    localparam logic [SAMPLE_W-1:0] THR_TWO_RST   = 10'd400;
    localparam logic [SAMPLE_W-1:0] THR_THREE_RST = 10'd600;
    localparam logic [SAMPLE_W-1:0] THR_FOUR_RST  = 10'd800;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD_ONE   = 2'd0,
        REG_THRESHOLD_TWO   = 2'd1,
        REG_THRESHOLD_THREE = 2'd2,
        REG_THRESHOLD_FOUR  = 2'd3
    } t_reg_idx;

    // Level band codes
    localparam logic [BAND_W-1:0] BAND_ZERO  = 3'd0;
    localparam logic [BAND_W-1:0] BAND_ONE   = 3'd1;
    localparam logic [BAND_W-1:0] BAND_TWO   = 3'd2;
    localparam logic [BAND_W-1:0] BAND_THREE = 3'd3;
    localparam logic [BAND_W-1:0] BAND_FOUR  = 3'd4;

    // One window slot handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] data;
    } t_slot;

    // Threshold set from the register block
    typedef struct packed {
        logic [SAMPLE_W-1:0] one;
        logic [SAMPLE_W-1:0] two;
        logic [SAMPLE_W-1:0] three;
        logic [SAMPLE_W-1:0] four;
    } t_thresholds;

endpackage

FILE: sv/malc_cell.sv
// One window cell: holds a sample and passes it on to the next cell on each shift.
module malc_cell
    import malc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_prev,
    output t_slot o_slot
);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_prev.data;
        end
    end

    // An empty cell reads as zero
    assign o_slot.valid = r_valid;
    assign o_slot.data  = r_valid ? r_data : '0;

endmodule

FILE: sv/malc_cfg.sv
// APB register block holding the four band thresholds.
module malc_cfg
    import malc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_thresholds o_thr
);

    t_thresholds r_thr;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_thr  = r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.one   <= THR_ONE_RST;
            r_thr.two   <= THR_TWO_RST;
            r_thr.three <= THR_THREE_RST;
            r_thr.four  <= THR_FOUR_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_THRESHOLD_ONE:   r_thr.one   <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD_TWO:   r_thr.two   <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD_THREE: r_thr.three <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD_FOUR:  r_thr.four  <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESHOLD_ONE:   prdata = 32'(r_thr.one);
            REG_THRESHOLD_TWO:   prdata = 32'(r_thr.two);
            REG_THRESHOLD_THREE: prdata = 32'(r_thr.three);
            REG_THRESHOLD_FOUR:  prdata = 32'(r_thr.four);
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: sv/moving_average_level_classifier_core.sv
// Top level of the moving-average level classifier: window chain, sum, divide and band stages.
//
// Usage:
//   s_axis carries one 10-bit converter sample per transaction in tdata[9:0].
//   m_axis returns one result per sample once the window holds WINDOW_LENGTH
//   samples: tdata[9:0] is the truncated window mean, tdata[12:10] the level
//   band 0..4. The first WINDOW_LENGTH-1 samples after reset give no result.
//   The APB port holds four thresholds at byte addresses 0, 4, 8 and 12; a
//   band's upper edge is inclusive and the first threshold at or above the
//   mean wins. Write them only while the block is idle.
// Timing:
//   One sample per cycle sustained while m_axis accepts results. The window
//   shift and the running-sum update happen together on the accepting edge,
//   which sets that rate. A result reaches m_axis through the sum register,
//   the reciprocal multiply register and the band/output register, in order.
// Reset:
//   Cell valid bits, the running sum and the pipeline valids clear at once; an
//   empty cell reads as zero. No clearing pass is needed.
// Stall:
//   A stalled m_axis holds its result; the inner stages keep filling bubbles
//   and s_axis_tready drops only once every stage holds a result.
module moving_average_level_classifier_core
    import malc_pkg::*;
#(
    parameter int WINDOW_LENGTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] sample, [15:10] zero
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] mean_value, [12:10] band, [15:13] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LOG_N   = $clog2(WINDOW_LENGTH);
    localparam int SUM_W   = SAMPLE_W + LOG_N;
    localparam int SHIFT_K = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Rounded-up reciprocal: exact quotient for every sum below 2**SUM_W
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT_K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [SUM_W-1:0] SUM_MAX =
        SUM_W'(WINDOW_LENGTH * ((1 << SAMPLE_W) - 1));

    t_thresholds w_thr;

    malc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (w_thr)
    );

    // Stage enables: a stage loads when it is empty or the next one loads
    logic w_en_o;
    logic w_en_2;
    logic w_en_1;
    logic w_accept;

    logic                r_s1_valid;
    logic [SUM_W-1:0]    r_s1_sum;
    logic                r_s2_valid;
    logic [SAMPLE_W-1:0] r_s2_mean;
    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_mean;
    logic [BAND_W-1:0]   r_o_band;

    assign w_en_o        = !r_o_valid || m_axis_tready;
    assign w_en_2        = !r_s2_valid || w_en_o;
    assign w_en_1        = !r_s1_valid || w_en_2;
    assign s_axis_tready = w_en_1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Window: a chain of cells, newest at the head, oldest drops off the tail
    t_slot w_chain [WINDOW_LENGTH+1];

    assign w_chain[0].valid = 1'b1;
    assign w_chain[0].data  = s_axis_tdata[SAMPLE_W-1:0];

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
        malc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_prev  (w_chain[g]),
            .o_slot  (w_chain[g+1])
        );
    end

    // Running sum: add the new sample, drop the one leaving the tail
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic             w_full_next;

    assign n_sum = r_sum + SUM_W'(w_chain[0].data) - SUM_W'(w_chain[WINDOW_LENGTH].data);
    // The window is full after this shift once the cell before the tail holds a sample
    assign w_full_next = w_chain[WINDOW_LENGTH-1].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_accept) begin
            r_sum <= n_sum;
        end
    end

    // Valid bits of the result pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_en_1) begin
                r_s1_valid <= w_accept && w_full_next;
            end
            if (w_en_2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_en_o) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // Divide by the window length as a multiply by its reciprocal
    logic [PROD_W-1:0] w_prod;
    assign w_prod = PROD_W'(r_s1_sum) * PROD_W'(RECIP);

    // Band by priority: first threshold at or above the mean
    logic [BAND_W-1:0] w_band;
    always_comb begin
        if (r_s2_mean <= w_thr.one) begin
            w_band = BAND_ZERO;
        end else if (r_s2_mean <= w_thr.two) begin
            w_band = BAND_ONE;
        end else if (r_s2_mean <= w_thr.three) begin
            w_band = BAND_TWO;
        end else if (r_s2_mean <= w_thr.four) begin
            w_band = BAND_THREE;
        end else begin
            w_band = BAND_FOUR;
        end
    end

    // Payload of the result pipeline, no reset
    always_ff @(posedge i_clk) begin
        if (w_en_1) begin
            r_s1_sum <= n_sum;
        end
        if (w_en_2) begin
            r_s2_mean <= w_prod[SHIFT_K +: SAMPLE_W];
        end
        if (w_en_o) begin
            r_o_mean <= r_s2_mean;
            r_o_band <= w_band;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'b000, r_o_band, r_o_mean};

    // A new result on the output comes only from a filled multiply stage
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s2_valid))
        else $error("output became valid without a result in the multiply stage");

    // Input stalls only when every stage holds a result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_s2_valid && r_o_valid))
        else $error("input stalled while the pipeline has a bubble");

    // Running sum stays within a full window of maximum samples
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_MAX)
        else $error("running sum out of range");

    // Band code of a result is one of the five bands
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_band <= BAND_FOUR))
        else $error("band code out of range");

endmodule
